[rtl/core/lfdc_pkg.sv]
package lfdc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_ARMED       = 3'd1,
    MODE_STOP        = 3'd2,
    MODE_STRAIGHT    = 3'd3,
    MODE_RIGHT       = 3'd4,
    MODE_SHARP_RIGHT = 3'd5,
    MODE_LEFT        = 3'd6,
    MODE_SHARP_LEFT  = 3'd7
  } drive_mode_e;

  // configuration register indexes
  localparam logic [2:0] CFG_PWM_TOP      = 3'd0;
  localparam logic [2:0] CFG_LIGHT_THRESH = 3'd1;
  localparam logic [2:0] CFG_LAP_MIN      = 3'd2;
  localparam logic [2:0] CFG_LAPS_TARGET  = 3'd3;
  localparam logic [2:0] CFG_BATT_OFFSET  = 3'd4;

  localparam logic [11:0] PwmTopRst      = 12'd1000;
  localparam logic [9:0]  LightThreshRst = 10'd250;
  localparam logic [7:0]  LapMinRst      = 8'd120;
  localparam logic [3:0]  LapsTargetRst  = 4'd3;
  localparam logic [9:0]  BattOffsetRst  = 10'd245;

  // wheel speeds per mode: right = lin - ang, left = lin + ang
  localparam logic [11:0] DutyStraight = 12'd400;
  localparam logic [11:0] DutyTurnIn   = 12'd150;
  localparam logic [11:0] DutyTurnOut  = 12'd450;
  localparam logic [11:0] SharpBack    = 12'd50;

  // highest battery difference that still maps to a level of ten or less
  localparam logic [9:0] BattDiffMax = 10'd109;

  typedef struct packed {
    logic       button_on;
    logic       sense_left;
    logic       sense_center_left;
    logic       sense_center;
    logic       sense_center_right;
    logic       sense_right;
    logic       tick;
    logic [9:0] battery_adc;
    logic [9:0] light_adc;
  } in_beat_t;

  // thermometer bar for diff / 10, valid for diff up to BattDiffMax
  function automatic logic [9:0] bar_level(input logic [9:0] diff);
    logic [9:0] bar;
    bar = '0;
    for (int k = 0; k < 10; k++) begin
      bar[k] = (diff >= 10'((k + 1) * 10));
    end
    return bar;
  endfunction

endpackage

[rtl/core/line_follower_drive_controller_unit.sv]
// Line-following drive controller. Each input beat is one control sample
// (button, five line sensors, a tick flag, battery and light ADC readings) and
// gives exactly one result beat: the new drive mode, both motor compare values
// with reverse flags, headlights, the ten-segment battery bar and the laps done.
// A sample is registered on entry and resolved from that input register into the
// result register, which also holds the controller state, once the output side
// does not stall; so one sample is taken every clock while the output side does
// not stall, and its result is presented from the result register. The input
// stalls only while a sample and a result both wait on a stalled output.
// Configuration writes are always ready and are meant to be issued only while
// no sample is in flight.
module line_follower_drive_controller_unit
  import lfdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        button_on_i,
  input  logic        sense_left_i,
  input  logic        sense_center_left_i,
  input  logic        sense_center_i,
  input  logic        sense_center_right_i,
  input  logic        sense_right_i,
  input  logic        tick_i,
  input  logic [9:0]  battery_adc_i,
  input  logic [9:0]  light_adc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  mode_o,
  output logic [11:0] right_duty_o,
  output logic        right_reverse_o,
  output logic [11:0] left_duty_o,
  output logic        left_reverse_o,
  output logic        headlights_o,
  output logic [9:0]  battery_bar_o,
  output logic [3:0]  laps_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  logic [11:0] pwm_top_q;
  logic [9:0]  light_thresh_q;
  logic [7:0]  lap_min_q;
  logic [3:0]  laps_target_q;
  logic [9:0]  batt_offset_q;

  in_beat_t    beat_q;
  logic        beat_vld_q;
  logic        out_vld_q;
  logic        load;

  drive_mode_e mode_q, mode_nxt, mode_d;
  logic [7:0]  tick_cnt_q, tick_cnt_d, tick_inc;
  logic [3:0]  lap_q, lap_d, lap_clr, lap_inc;
  logic        run_clear;
  logic        lap_hit;
  logic [11:0] r_duty_q, r_duty_d, l_duty_q, l_duty_d;
  logic        r_rev_q, r_rev_d, l_rev_q, l_rev_d;
  logic [9:0]  bar_q, bar_d, batt_diff;
  logic        lights_q, lights_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_top_q      <= PwmTopRst;
      light_thresh_q <= LightThreshRst;
      lap_min_q      <= LapMinRst;
      laps_target_q  <= LapsTargetRst;
      batt_offset_q  <= BattOffsetRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PWM_TOP:      pwm_top_q      <= cfg_data_i;
        CFG_LIGHT_THRESH: light_thresh_q <= cfg_data_i[9:0];
        CFG_LAP_MIN:      lap_min_q      <= cfg_data_i[7:0];
        CFG_LAPS_TARGET:  laps_target_q  <= cfg_data_i[3:0];
        CFG_BATT_OFFSET:  batt_offset_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // input register, result register stands behind it
  assign load       = beat_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = beat_vld_q && out_vld_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        beat_vld_q <= in_valid_i;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      beat_q <= '{button_on:          button_on_i,
                  sense_left:         sense_left_i,
                  sense_center_left:  sense_center_left_i,
                  sense_center:       sense_center_i,
                  sense_center_right: sense_center_right_i,
                  sense_right:        sense_right_i,
                  tick:               tick_i,
                  battery_adc:        battery_adc_i,
                  light_adc:          light_adc_i};
    end
  end

  // mode transition, first matching rule wins
  always_comb begin
    mode_nxt = mode_q;
    unique case (mode_q)
      MODE_IDLE: begin
        if (beat_q.button_on) mode_nxt = MODE_ARMED;
      end
      MODE_ARMED: begin
        if (!beat_q.button_on) mode_nxt = MODE_STRAIGHT;
      end
      MODE_STOP: begin
        if (!beat_q.button_on) mode_nxt = MODE_IDLE;
      end
      MODE_STRAIGHT: begin
        if (beat_q.button_on)               mode_nxt = MODE_STOP;
        else if (beat_q.sense_center_right) mode_nxt = MODE_RIGHT;
        else if (beat_q.sense_center_left)  mode_nxt = MODE_LEFT;
      end
      MODE_RIGHT: begin
        if (beat_q.button_on)              mode_nxt = MODE_STOP;
        else if (beat_q.sense_right)       mode_nxt = MODE_SHARP_RIGHT;
        else if (beat_q.sense_center)      mode_nxt = MODE_STRAIGHT;
        else if (beat_q.sense_center_left) mode_nxt = MODE_LEFT;
      end
      MODE_SHARP_RIGHT: begin
        if (beat_q.button_on)               mode_nxt = MODE_STOP;
        else if (beat_q.sense_center_right) mode_nxt = MODE_RIGHT;
        else if (beat_q.sense_center_left)  mode_nxt = MODE_LEFT;
      end
      MODE_LEFT: begin
        if (beat_q.button_on)               mode_nxt = MODE_STOP;
        else if (beat_q.sense_left)         mode_nxt = MODE_SHARP_LEFT;
        else if (beat_q.sense_center)       mode_nxt = MODE_STRAIGHT;
        else if (beat_q.sense_center_right) mode_nxt = MODE_RIGHT;
      end
      MODE_SHARP_LEFT: begin
        if (beat_q.button_on)               mode_nxt = MODE_STOP;
        else if (beat_q.sense_center_left)  mode_nxt = MODE_LEFT;
        else if (beat_q.sense_center_right) mode_nxt = MODE_RIGHT;
      end
      default: mode_nxt = mode_q;
    endcase
  end

  // motor drive from the transitioned mode; stopping keeps the last duties
  always_comb begin
    r_duty_d = r_duty_q;
    l_duty_d = l_duty_q;
    r_rev_d  = r_rev_q;
    l_rev_d  = l_rev_q;
    unique case (mode_nxt)
      MODE_IDLE, MODE_ARMED: begin
        r_duty_d = '0;
        l_duty_d = '0;
        r_rev_d  = 1'b0;
        l_rev_d  = 1'b0;
      end
      MODE_STRAIGHT: begin
        r_duty_d = DutyStraight;
        l_duty_d = DutyStraight;
        r_rev_d  = 1'b0;
        l_rev_d  = 1'b0;
      end
      MODE_RIGHT: begin
        r_duty_d = DutyTurnIn;
        l_duty_d = DutyTurnOut;
        r_rev_d  = 1'b0;
        l_rev_d  = 1'b0;
      end
      MODE_SHARP_RIGHT: begin
        r_duty_d = pwm_top_q - SharpBack;
        l_duty_d = DutyTurnOut;
        r_rev_d  = 1'b1;
        l_rev_d  = 1'b0;
      end
      MODE_LEFT: begin
        r_duty_d = DutyTurnOut;
        l_duty_d = DutyTurnIn;
        r_rev_d  = 1'b0;
        l_rev_d  = 1'b0;
      end
      MODE_SHARP_LEFT: begin
        r_duty_d = DutyTurnOut;
        l_duty_d = pwm_top_q - SharpBack;
        r_rev_d  = 1'b0;
        l_rev_d  = 1'b1;
      end
      default: ;
    endcase
  end

  // tick count, run start clear, lap check and target
  always_comb begin
    run_clear  = (mode_q == MODE_ARMED) && !beat_q.button_on;
    tick_inc   = beat_q.tick ? tick_cnt_q + 8'd1 : tick_cnt_q;
    tick_cnt_d = run_clear ? '0 : tick_inc;
    lap_clr    = run_clear ? '0 : lap_q;
    lap_hit    = (tick_cnt_d >= lap_min_q) && beat_q.sense_right && beat_q.sense_left;
    lap_inc    = lap_hit ? lap_clr + 4'd1 : lap_clr;
    if (lap_hit) tick_cnt_d = '0;
    mode_d = mode_nxt;
    lap_d  = lap_inc;
    if (lap_inc == laps_target_q) begin
      lap_d  = '0;
      mode_d = MODE_IDLE;
    end
  end

  always_comb begin
    batt_diff = beat_q.battery_adc - batt_offset_q;
    bar_d     = bar_q;
    if (beat_q.battery_adc >= batt_offset_q && batt_diff <= BattDiffMax) begin
      bar_d = bar_level(batt_diff);
    end
    lights_d = beat_q.light_adc < light_thresh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      tick_cnt_q <= '0;
      lap_q      <= '0;
      r_duty_q   <= '0;
      l_duty_q   <= '0;
      r_rev_q    <= 1'b0;
      l_rev_q    <= 1'b0;
      bar_q      <= '0;
    end else if (load) begin
      mode_q     <= mode_d;
      tick_cnt_q <= tick_cnt_d;
      lap_q      <= lap_d;
      r_duty_q   <= r_duty_d;
      l_duty_q   <= l_duty_d;
      r_rev_q    <= r_rev_d;
      l_rev_q    <= l_rev_d;
      bar_q      <= bar_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lights_q <= lights_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign mode_o          = mode_q;
  assign right_duty_o    = r_duty_q;
  assign right_reverse_o = r_rev_q;
  assign left_duty_o     = l_duty_q;
  assign left_reverse_o  = l_rev_q;
  assign headlights_o    = lights_q;
  assign battery_bar_o   = bar_q;
  assign laps_done_o     = lap_q;

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_stop_holds_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && mode_nxt == MODE_STOP) |=> ($stable(right_duty_o) && $stable(left_duty_o)))
    else $error("stopping mode changed the motor duties");

  a_run_start_clears_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && mode_q == MODE_ARMED && !beat_q.button_on) |=> tick_cnt_q == 8'd0)
    else $error("tick count not cleared at run start");

  a_bar_thermometer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((battery_bar_o + 10'd1) & battery_bar_o) == 10'd0)
    else $error("battery bar is not a thermometer code");
`endif

endmodule

[tb/testbench.sv]
module testbench;
  import lfdc_pkg::*;

  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned PhaseCount  = 8;

  // sensor masks, ordered {left, center-left, center, center-right, right}
  localparam logic [4:0] SEN_NONE   = 5'b00000;
  localparam logic [4:0] SEN_LEFT   = 5'b10000;
  localparam logic [4:0] SEN_CLEFT  = 5'b01000;
  localparam logic [4:0] SEN_CENTER = 5'b00100;
  localparam logic [4:0] SEN_CRIGHT = 5'b00010;
  localparam logic [4:0] SEN_RIGHT  = 5'b00001;
  localparam logic [4:0] SEN_OUTER  = 5'b10001;
  localparam logic [4:0] SEN_ALL    = 5'b11111;

  typedef struct packed {
    drive_mode_e mode;
    logic [11:0] right_duty;
    logic        right_reverse;
    logic [11:0] left_duty;
    logic        left_reverse;
    logic        headlights;
    logic [9:0]  battery_bar;
    logic [3:0]  laps_done;
  } drive_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        button_on_i;
  logic        sense_left_i;
  logic        sense_center_left_i;
  logic        sense_center_i;
  logic        sense_center_right_i;
  logic        sense_right_i;
  logic        tick_i;
  logic [9:0]  battery_adc_i;
  logic [9:0]  light_adc_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  mode_o;
  logic [11:0] right_duty_o;
  logic        right_reverse_o;
  logic [11:0] left_duty_o;
  logic        left_reverse_o;
  logic        headlights_o;
  logic [9:0]  battery_bar_o;
  logic [3:0]  laps_done_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  line_follower_drive_controller_unit u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // controller copy used to predict each result
  drive_mode_e cur_mode;
  logic [7:0]  tick_total;
  logic [3:0]  lap_total;
  logic [11:0] right_duty_q, left_duty_q;
  logic        right_rev_q, left_rev_q;
  logic [9:0]  bar_q;
  logic [11:0] pwm_top;
  logic [9:0]  light_thresh;
  logic [7:0]  lap_min_ticks;
  logic [3:0]  laps_target;
  logic [9:0]  batt_offset;

  drive_result_t expected_results[$];
  int unsigned   mismatch_count = 0;
  bit            gaps_on;
  int unsigned   stall_left = 0;
  int unsigned   stuck_cycles = 0;

  function automatic void wheel_duty(input int speed, output logic [11:0] duty,
                                     output logic rev);
    if (speed < 0) begin
      duty = pwm_top - 12'(-speed);
      rev  = 1'b1;
    end else begin
      duty = 12'(speed);
      rev  = 1'b0;
    end
  endfunction

  function automatic drive_result_t predict_controller(input in_beat_t s);
    drive_mode_e   m;
    int            lin;
    int            ang;
    logic [9:0]    diff;
    int            lvl;
    drive_result_t r;
    m = cur_mode;
    if (s.tick) tick_total = tick_total + 8'd1;

    if (m == MODE_IDLE && s.button_on) m = MODE_ARMED;
    else if (m == MODE_ARMED && !s.button_on) begin
      lap_total  = '0;
      tick_total = '0;
      m = MODE_STRAIGHT;
    end
    else if (m != MODE_IDLE && m != MODE_ARMED && s.button_on) m = MODE_STOP;
    else if (m == MODE_STOP) m = MODE_IDLE;
    else if (m == MODE_STRAIGHT && s.sense_center_right) m = MODE_RIGHT;
    else if (m == MODE_STRAIGHT && s.sense_center_left) m = MODE_LEFT;
    else if (m == MODE_RIGHT && s.sense_right) m = MODE_SHARP_RIGHT;
    else if (m == MODE_LEFT && s.sense_left) m = MODE_SHARP_LEFT;
    else if (m == MODE_RIGHT && s.sense_center) m = MODE_STRAIGHT;
    else if (m == MODE_SHARP_RIGHT && s.sense_center_right) m = MODE_RIGHT;
    else if (m == MODE_LEFT && s.sense_center) m = MODE_STRAIGHT;
    else if (m == MODE_SHARP_LEFT && s.sense_center_left) m = MODE_LEFT;
    else if (m == MODE_LEFT && s.sense_center_right) m = MODE_RIGHT;
    else if (m == MODE_RIGHT && s.sense_center_left) m = MODE_LEFT;
    else if (m == MODE_SHARP_LEFT && s.sense_center_right) m = MODE_RIGHT;
    else if (m == MODE_SHARP_RIGHT && s.sense_center_left) m = MODE_LEFT;

    lin = 0;
    ang = 0;
    case (m)
      MODE_STRAIGHT:    lin = 400;
      MODE_RIGHT:       begin lin = 300; ang = 150; end
      MODE_SHARP_RIGHT: begin lin = 200; ang = 250; end
      MODE_LEFT:        begin lin = 300; ang = -150; end
      MODE_SHARP_LEFT:  begin lin = 200; ang = -250; end
      default: ;
    endcase
    // stopping keeps the last driven duties
    if (m != MODE_STOP) begin
      wheel_duty(lin - ang, right_duty_q, right_rev_q);
      wheel_duty(lin + ang, left_duty_q, left_rev_q);
    end

    if (s.battery_adc >= batt_offset) begin
      diff = s.battery_adc - batt_offset;
      lvl  = int'(diff) / 10;
      if (lvl <= 10) bar_q = 10'((1 << lvl) - 1);
    end

    r.headlights = (s.light_adc < light_thresh);

    if (tick_total >= lap_min_ticks && s.sense_right && s.sense_left) begin
      lap_total  = lap_total + 4'd1;
      tick_total = '0;
    end
    if (lap_total == laps_target) begin
      lap_total = '0;
      m = MODE_IDLE;
    end
    cur_mode = m;

    r.mode          = m;
    r.right_duty    = right_duty_q;
    r.right_reverse = right_rev_q;
    r.left_duty     = left_duty_q;
    r.left_reverse  = left_rev_q;
    r.battery_bar   = bar_q;
    r.laps_done     = lap_total;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_sample(input in_beat_t s);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    button_on_i          <= s.button_on;
    sense_left_i         <= s.sense_left;
    sense_center_left_i  <= s.sense_center_left;
    sense_center_i       <= s.sense_center;
    sense_center_right_i <= s.sense_center_right;
    sense_right_i        <= s.sense_right;
    tick_i               <= s.tick;
    battery_adc_i        <= s.battery_adc;
    light_adc_i          <= s.light_adc;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_controller(s));
  endtask

  task automatic send_fields(input logic on, input logic [4:0] sen, input logic tk,
                             input logic [9:0] batt, input logic [9:0] light);
    in_beat_t s;
    s.button_on          = on;
    s.sense_left         = sen[4];
    s.sense_center_left  = sen[3];
    s.sense_center       = sen[2];
    s.sense_center_right = sen[1];
    s.sense_right        = sen[0];
    s.tick               = tk;
    s.battery_adc        = batt;
    s.light_adc          = light;
    send_sample(s);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [11:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PWM_TOP:      pwm_top       = data;
      CFG_LIGHT_THRESH: light_thresh  = data[9:0];
      CFG_LAP_MIN:      lap_min_ticks = data[7:0];
      CFG_LAPS_TARGET:  laps_target   = data[3:0];
      CFG_BATT_OFFSET:  batt_offset   = data[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [11:0] top, input logic [9:0] thr,
                           input logic [7:0] lmin, input logic [3:0] target,
                           input logic [9:0] offs);
    write_register(CFG_PWM_TOP, top);
    write_register(CFG_LIGHT_THRESH, 12'(thr));
    write_register(CFG_LAP_MIN, 12'(lmin));
    write_register(CFG_LAPS_TARGET, 12'(target));
    write_register(CFG_BATT_OFFSET, 12'(offs));
  endtask

  // let every sample in flight come out before touching the registers
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [9:0] rand_battery();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 1023;
      2, 3:    v = $urandom_range(0, 1023);
      default: v = int'(batt_offset) + $urandom_range(0, 118) - 3;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  function automatic logic [9:0] rand_light();
    int v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 1023;
      2:       v = int'(light_thresh) + $urandom_range(0, 4) - 2;
      default: v = $urandom_range(0, 1023);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  task automatic test_directed_modes();
    send_fields(1'b0, SEN_NONE,   1'b0, 10'd0,    10'd0);
    send_fields(1'b1, SEN_ALL,    1'b1, 10'd1023, 10'd1023);
    send_fields(1'b0, SEN_NONE,   1'b1, 10'd245,  10'd249);
    send_fields(1'b0, SEN_CRIGHT, 1'b1, 10'd255,  10'd250);
    send_fields(1'b0, SEN_RIGHT,  1'b1, 10'd354,  10'd251);
    send_fields(1'b0, SEN_CRIGHT, 1'b0, 10'd355,  10'd100);
    send_fields(1'b0, SEN_CENTER, 1'b1, 10'd300,  10'd300);
    send_fields(1'b0, SEN_CLEFT,  1'b1, 10'd244,  10'd0);
    send_fields(1'b0, SEN_LEFT,   1'b1, 10'd400,  10'd1023);
    send_fields(1'b0, SEN_CLEFT,  1'b0, 10'd250,  10'd5);
    send_fields(1'b0, SEN_CRIGHT, 1'b1, 10'd260,  10'd700);
    send_fields(1'b0, SEN_CLEFT,  1'b1, 10'd270,  10'd700);
    send_fields(1'b0, SEN_CENTER, 1'b1, 10'd280,  10'd700);
    send_fields(1'b0, SEN_CRIGHT, 1'b1, 10'd290,  10'd700);
    send_fields(1'b0, SEN_RIGHT,  1'b1, 10'd310,  10'd700);
    send_fields(1'b0, SEN_CLEFT,  1'b1, 10'd320,  10'd700);
    send_fields(1'b0, SEN_LEFT,   1'b1, 10'd330,  10'd700);
    send_fields(1'b0, SEN_CRIGHT, 1'b1, 10'd340,  10'd700);
    send_fields(1'b1, SEN_NONE,   1'b1, 10'd350,  10'd10);
    send_fields(1'b1, SEN_ALL,    1'b0, 10'd1023, 10'd10);
    send_fields(1'b0, SEN_ALL,    1'b1, 10'd0,    10'd10);
    send_fields(1'b0, SEN_ALL,    1'b1, 10'd245,  10'd1023);
    drain_results();
  endtask

  task automatic test_corner_configs();
    // pwm period shorter than the reverse speed wraps the duty
    write_all(12'd20, 10'd1023, 8'd255, 4'd15, 10'd0);
    send_fields(1'b1, SEN_NONE,   1'b0, 10'd5,   10'd1022);
    send_fields(1'b0, SEN_NONE,   1'b1, 10'd109, 10'd1023);
    send_fields(1'b0, SEN_CRIGHT, 1'b1, 10'd110, 10'd0);
    send_fields(1'b0, SEN_RIGHT,  1'b1, 10'd9,   10'd0);
    send_fields(1'b0, SEN_CLEFT,  1'b1, 10'd10,  10'd0);
    send_fields(1'b0, SEN_LEFT,   1'b1, 10'd20,  10'd0);
    send_fields(1'b1, SEN_OUTER,  1'b1, 10'd30,  10'd0);
    send_fields(1'b0, SEN_OUTER,  1'b1, 10'd40,  10'd0);
    drain_results();
    // zero lap target forces idle on every sample
    write_register(CFG_LAPS_TARGET, 12'd0);
    send_fields(1'b1, SEN_NONE,  1'b1, 10'd50, 10'd0);
    send_fields(1'b0, SEN_OUTER, 1'b1, 10'd60, 10'd0);
    send_fields(1'b1, SEN_ALL,   1'b0, 10'd70, 10'd0);
    drain_results();
    // lap target reached: mode drops to idle, motors follow the prior mode
    write_all(12'd4095, 10'd0, 8'd0, 4'd2, 10'd1023);
    send_fields(1'b1, SEN_NONE,  1'b0, 10'd1023, 10'd0);
    send_fields(1'b0, SEN_NONE,  1'b1, 10'd1023, 10'd0);
    send_fields(1'b0, SEN_OUTER, 1'b0, 10'd1022, 10'd0);
    send_fields(1'b0, SEN_RIGHT, 1'b1, 10'd1023, 10'd0);
    send_fields(1'b0, SEN_OUTER, 1'b1, 10'd0,    10'd0);
    drain_results();
  endtask

  // arm, start and drive one run with random sensor readings
  task automatic drive_run(output int unsigned sent);
    int unsigned presses;
    int unsigned len;
    presses = $urandom_range(1, 2);
    len     = $urandom_range(8, 40);
    sent    = presses + 1 + len;
    repeat (presses)
      send_fields(1'b1, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  rand_battery(), rand_light());
    send_fields(1'b0, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                rand_battery(), rand_light());
    repeat (len)
      send_fields(1'($urandom_range(0, 39) == 0), 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 3) != 0), rand_battery(), rand_light());
  endtask

  task automatic test_random_runs();
    int unsigned n;
    int unsigned sent;
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 0) begin
        write_all(12'd500, 10'd0, 8'd0, 4'd1, 10'd0);
      end else if (ph == 1) begin
        write_all(12'd4095, 10'd1023, 8'd255, 4'd15, 10'd1023);
      end else begin
        write_all(12'($urandom_range(500, 4095)), 10'($urandom_range(0, 1023)),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 24)),
                  4'($urandom_range(1, 15)), 10'($urandom_range(0, 1023)));
      end
      // every third phase (ph % 3 == 2) and the final phase run at full rate on both sides
      gaps_on = (ph + 1 < PhaseCount) && (ph % 3 != 2);
      n = 0;
      while (n < PhaseItems) begin
        if ($urandom_range(0, 6) != 0) begin
          drive_run(sent);
          n += sent;
        end else begin
          send_fields(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                      1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)));
          n++;
        end
      end
      drain_results();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    drive_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected, mode %0d", mode_o));
      end else begin
        e = expected_results.pop_front();
        if (mode_o !== e.mode)
          report_mismatch($sformatf("mode %0d, want %0d", mode_o, e.mode));
        if (right_duty_o !== e.right_duty)
          report_mismatch($sformatf("right_duty %0d, want %0d", right_duty_o, e.right_duty));
        if (right_reverse_o !== e.right_reverse)
          report_mismatch($sformatf("right_reverse %0b, want %0b", right_reverse_o,
                                    e.right_reverse));
        if (left_duty_o !== e.left_duty)
          report_mismatch($sformatf("left_duty %0d, want %0d", left_duty_o, e.left_duty));
        if (left_reverse_o !== e.left_reverse)
          report_mismatch($sformatf("left_reverse %0b, want %0b", left_reverse_o,
                                    e.left_reverse));
        if (headlights_o !== e.headlights)
          report_mismatch($sformatf("headlights %0b, want %0b", headlights_o, e.headlights));
        if (battery_bar_o !== e.battery_bar)
          report_mismatch($sformatf("battery_bar %b, want %b", battery_bar_o, e.battery_bar));
        if (laps_done_o !== e.laps_done)
          report_mismatch($sformatf("laps_done %0d, want %0d", laps_done_o, e.laps_done));
      end
    end
  end

  // output side stall bursts
  always @(negedge clk_i) begin
    if (!gaps_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles where no beat moves anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    in_valid_i           = 1'b0;
    button_on_i          = 1'b0;
    sense_left_i         = 1'b0;
    sense_center_left_i  = 1'b0;
    sense_center_i       = 1'b0;
    sense_center_right_i = 1'b0;
    sense_right_i        = 1'b0;
    tick_i               = 1'b0;
    battery_adc_i        = '0;
    light_adc_i          = '0;
    cfg_valid_i          = 1'b0;
    cfg_index_i          = '0;
    cfg_data_i           = '0;
    gaps_on              = 1'b0;
    cur_mode             = MODE_IDLE;
    tick_total           = '0;
    lap_total            = '0;
    right_duty_q         = '0;
    left_duty_q          = '0;
    right_rev_q          = 1'b0;
    left_rev_q           = 1'b0;
    bar_q                = '0;
    pwm_top              = PwmTopRst;
    light_thresh         = LightThreshRst;
    lap_min_ticks        = LapMinRst;
    laps_target          = LapsTargetRst;
    batt_offset          = BattOffsetRst;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    gaps_on = 1'b1;
    test_directed_modes();
    test_corner_configs();
    test_random_runs();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
